// ----- design/line_position_pid_drive_top_defines.svh -----
// assertion macros for the line position pid drive block
`ifndef LINE_POSITION_PID_DRIVE_TOP_DEFINES_SVH
`define LINE_POSITION_PID_DRIVE_TOP_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication, checked on every rising edge out of reset
`define LPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpd check failed");
// next-cycle implication
`define LPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpd check failed");
`else
`define LPD_ASSERT_SAME(lbl, ante, cons)
`define LPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/lpd_pkg.sv -----
// shared types and constants for the line position pid drive block
package lpd_pkg;

  localparam int READ_W     = 10;
  localparam int THR_W      = 10;
  localparam int GAIN_W     = 24;
  localparam int LIM_W      = 13;
  localparam int DUTY_W     = 15;
  localparam int ERR_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int WSUM_W     = 13;
  localparam int SUM_W      = 13;
  localparam int MAG_W      = 12;
  localparam int PROD_W     = 40;
  localparam int ACC_W      = 42;
  localparam int DUTY_FRAC  = 8;
  localparam int MUL_STEPS  = 3;
  localparam int MCNT_W     = 2;

  localparam logic signed [ERR_W-1:0] ERR_MAX   = 14'sd8191;
  localparam logic signed [ERR_W-1:0] ERR_MIN   = -14'sd8191;
  localparam logic signed [ERR_W-1:0] ERR_NEVER = 14'sh2000;

  localparam logic [THR_W-1:0]  THR_RST   = 10'd100;
  localparam logic [GAIN_W-1:0] PGAIN_RST = 24'd2293760;
  localparam logic [GAIN_W-1:0] IGAIN_RST = 24'd655;
  localparam logic [GAIN_W-1:0] DGAIN_RST = 24'd3932160;
  localparam logic [LIM_W-1:0]  LIM_RST   = 13'd7680;
  localparam logic [DUTY_W-1:0] BASE_RST  = 15'd22528;
  localparam logic [DUTY_W-1:0] MIN_RST   = 15'd14848;
  localparam logic [DUTY_W-1:0] MAX_RST   = 15'd23808;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLACK_THR  = 3'd0,
    REG_PROP_GAIN  = 3'd1,
    REG_INTEG_GAIN = 3'd2,
    REG_DERIV_GAIN = 3'd3,
    REG_INTEG_LIM  = 3'd4,
    REG_BASE_DUTY  = 3'd5,
    REG_MIN_DUTY   = 3'd6,
    REG_MAX_DUTY   = 3'd7
  } lpd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ERR,
    ST_MUL,
    ST_DRAIN,
    ST_CORR,
    ST_LEFT,
    ST_RIGHT
  } lpd_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lpd_div_stat_t;

  typedef struct packed {
    logic clear;
    logic en;
  } lpd_mac_ctl_t;

endpackage

// ----- design/lpd_chan_if.sv -----
// valid/ready channel interfaces for sensor items and drive results
interface lpd_in_if import lpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [READ_W-1:0] reading_far_left;
  logic [READ_W-1:0] reading_left;
  logic [READ_W-1:0] reading_center;
  logic [READ_W-1:0] reading_right;
  logic [READ_W-1:0] reading_far_right;

  modport source (
    output valid, reading_far_left, reading_left, reading_center,
           reading_right, reading_far_right,
    input  ready
  );
  modport sink (
    input  valid, reading_far_left, reading_left, reading_center,
           reading_right, reading_far_right,
    output ready
  );
endinterface

interface lpd_out_if import lpd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [DUTY_W-1:0]       left_duty;
  logic [DUTY_W-1:0]       right_duty;
  logic signed [ERR_W-1:0] line_error;
  logic                    line_lost;

  modport source (
    output valid, left_duty, right_duty, line_error, line_lost,
    input  ready
  );
  modport sink (
    input  valid, left_duty, right_duty, line_error, line_lost,
    output ready
  );
endinterface

// ----- design/line_position_pid_drive_top.sv -----
// line follower: weighted centroid position, pid correction, wheel duties
//
// in_ch carries one item of five line-sensor readings; out_ch returns one
// item per input: left and right wheel duty (Q7.8 percent), the scaled
// position error (signed Q.ERROR_FRAC_BITS) and a line-lost flag.
// Both channels use valid/ready; an item moves when both are high.
// The cfg port writes one of eight registers per cycle with cfg_we high;
// write only while no item is in flight.
// Steps: an item with the line in view runs through a restoring divider
// that yields one quotient bit per cycle (ERROR_FRAC_BITS+2 bits), then
// the error step, three multiplies on one shared multiplier, a drain step,
// the correction and the left and right duty steps; with the line lost the
// divider is skipped. in_ch.ready is high only in idle, so a new item is
// taken only after the last one has left its last step.
// The output register holds a result until taken, and the next item may be
// accepted meanwhile; it then waits in its last step for the register.
// Reset (synchronous, rst_n low) loads register defaults, clears the
// last error and the integral, and drops out_ch.valid.
module line_position_pid_drive_top import lpd_pkg::*; #(
  parameter int ERROR_FRAC_BITS = 8,
  parameter int GAIN_FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lpd_in_if.sink                in_ch,
  lpd_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "line_position_pid_drive_top_defines.svh"

  // quotient bits: |position| <= 3 in Q.ERROR_FRAC_BITS
  localparam int QUO_W  = ERROR_FRAC_BITS + 2;
  localparam int NUM_W  = MAG_W + ERROR_FRAC_BITS;
  localparam int POS_W  = ERROR_FRAC_BITS + 3;
  localparam int EW_RAW = ERROR_FRAC_BITS + 7;
  localparam int EW     = (EW_RAW > ERR_W + 1) ? EW_RAW : ERR_W + 1;
  localparam int SH     = ERROR_FRAC_BITS + GAIN_FRAC_BITS - DUTY_FRAC;
  localparam int DV_W   = ACC_W + 1;
  localparam logic [POS_W-1:0] POS_LOST = POS_W'(3) << ERROR_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] RND = (ACC_W'(1) << SH) - ACC_W'(1);

  // configuration registers
  logic [THR_W-1:0]  thr_r;
  logic [GAIN_W-1:0] pgain_r, igain_r, dgain_r;
  logic [LIM_W-1:0]  lim_r;
  logic [DUTY_W-1:0] base_r, min_r, max_r;

  // sequencer
  lpd_state_t         state_r, state_nxt;
  logic [MCNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic               in_acc;
  logic               out_load;
  logic               div_start;
  lpd_div_stat_t      div_stat;
  lpd_mac_ctl_t       mac_ctl;

  // per-item working values
  logic                    lost_r, neg_r;
  logic signed [ERR_W-1:0] err_r, integ_r;
  logic signed [ERR_W:0]   diff_r;
  logic signed [ACC_W-1:0] corr_r;
  logic [DUTY_W-1:0]       left_r;

  // loop state
  logic signed [ERR_W-1:0] last_err_r, ierr_r;

  // output register
  logic                    out_valid_r;
  logic [DUTY_W-1:0]       out_left_r, out_right_r;
  logic signed [ERR_W-1:0] out_err_r;
  logic                    out_lost_r;

  // accept-cycle sums of the readings
  logic signed [WSUM_W-1:0] e_fl, e_l, e_r, e_fr;
  logic signed [WSUM_W-1:0] wsum_c;
  logic [SUM_W-1:0]         sum_c;
  logic [MAG_W-1:0]         mag_c;
  logic [NUM_W-1:0]         num_c;
  logic                     lost_c;

  logic [QUO_W-1:0] quo;

  // error stage
  logic [POS_W-1:0]        qx_c;
  logic signed [POS_W-1:0] pos_c;
  logic signed [EW-1:0]    pos_x, err_w;
  logic signed [ERR_W-1:0] err_c;
  logic signed [ERR_W:0]   diff_c, isum_c, lim_c;
  logic signed [ERR_W-1:0] integ_c;

  // multiply operands
  logic [GAIN_W-1:0]     mgain_c;
  logic signed [ERR_W:0] mopnd_c;
  logic signed [ACC_W-1:0] acc;

  // correction and duty bounding
  logic signed [ACC_W-1:0] corr_c;
  logic signed [DV_W-1:0]  base_x, lo_x, hi_x, corr_x, dv_c;
  logic [DUTY_W-1:0]       duty_c;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // weights +3 +1 0 -1 -3; the center reading only adds to the plain sum
  assign e_fl   = $signed(WSUM_W'(in_ch.reading_far_left));
  assign e_l    = $signed(WSUM_W'(in_ch.reading_left));
  assign e_r    = $signed(WSUM_W'(in_ch.reading_right));
  assign e_fr   = $signed(WSUM_W'(in_ch.reading_far_right));
  assign wsum_c = (e_fl <<< 1) + e_fl + e_l - e_r - (e_fr <<< 1) - e_fr;
  assign sum_c  = SUM_W'(in_ch.reading_far_left) + SUM_W'(in_ch.reading_left)
                + SUM_W'(in_ch.reading_center) + SUM_W'(in_ch.reading_right)
                + SUM_W'(in_ch.reading_far_right);
  assign mag_c  = wsum_c[WSUM_W-1] ? MAG_W'(-wsum_c) : MAG_W'(wsum_c);
  assign num_c  = {mag_c, {ERROR_FRAC_BITS{1'b0}}};
  // a zero sum means every reading is at or below threshold, so lost covers it
  assign lost_c = (in_ch.reading_far_left <= thr_r) && (in_ch.reading_left <= thr_r)
               && (in_ch.reading_center <= thr_r) && (in_ch.reading_right <= thr_r)
               && (in_ch.reading_far_right <= thr_r);

  lpd_div #(
    .QUO_W (QUO_W),
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_c),
    .den   (sum_c),
    .quo   (quo),
    .stat  (div_stat)
  );

  // position: signed quotient, or +-3 following the last error when lost
  assign qx_c = POS_W'(quo);
  always_comb begin
    if (lost_r) begin
      pos_c = (last_err_r > 0) ? POS_LOST : -POS_LOST;
    end else begin
      pos_c = neg_r ? -qx_c : qx_c;
    end
  end

  // error = 10 * position, saturated to the output width
  assign pos_x = EW'(pos_c);
  assign err_w = (pos_x <<< 3) + (pos_x <<< 1);
  always_comb begin
    priority if (err_w > EW'(ERR_MAX)) begin
      err_c = ERR_MAX;
    end else if (err_w < EW'(ERR_MIN)) begin
      err_c = ERR_MIN;
    end else begin
      err_c = err_w[ERR_W-1:0];
    end
  end

  assign diff_c = (ERR_W+1)'(err_c) - (ERR_W+1)'(last_err_r);
  assign isum_c = (ERR_W+1)'(ierr_r) + (ERR_W+1)'(err_c);
  assign lim_c  = $signed((ERR_W+1)'(lim_r));

  always_comb begin
    priority if (isum_c < -lim_c) begin
      integ_c = ERR_W'(-lim_c);
    end else if (isum_c > lim_c) begin
      integ_c = ERR_W'(lim_c);
    end else begin
      integ_c = ERR_W'(isum_c);
    end
  end

  // one product per cycle: p*err, i*integral, d*diff
  always_comb begin
    unique case (mcnt_r)
      2'd0: begin
        mgain_c = pgain_r;
        mopnd_c = (ERR_W+1)'(err_r);
      end
      2'd1: begin
        mgain_c = igain_r;
        mopnd_c = (ERR_W+1)'(integ_r);
      end
      2'd2: begin
        mgain_c = dgain_r;
        mopnd_c = diff_r;
      end
      default: begin
        mgain_c = '0;
        mopnd_c = '0;
      end
    endcase
  end

  lpd_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .gain  (mgain_c),
    .opnd  (mopnd_c),
    .acc   (acc)
  );

  // to Q.8, truncating toward zero
  assign corr_c = (acc + (acc[ACC_W-1] ? RND : ACC_W'(0))) >>> SH;

  // shared add and bound: left uses base - corr, right base + corr
  assign base_x = $signed(DV_W'(base_r));
  assign lo_x   = $signed(DV_W'(min_r));
  assign hi_x   = $signed(DV_W'(max_r));
  assign corr_x = DV_W'(corr_r);
  assign dv_c   = base_x + ((state_r == ST_LEFT) ? -corr_x : corr_x);

  // max is checked first: when the two cross, a value above max gets max
  always_comb begin
    priority if (dv_c > hi_x) begin
      duty_c = max_r;
    end else if (dv_c < lo_x) begin
      duty_c = min_r;
    end else begin
      duty_c = dv_c[DUTY_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mcnt_nxt  = mcnt_r;
    div_start = 1'b0;
    mac_ctl   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          div_start = !lost_c;
          state_nxt = lost_c ? ST_ERR : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        mac_ctl.clear = 1'b1;
        mcnt_nxt      = '0;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        mac_ctl.en = 1'b1;
        if (mcnt_r == MCNT_W'(MUL_STEPS - 1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          mcnt_nxt = mcnt_r + MCNT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_CORR;
      end
      ST_CORR: begin
        state_nxt = ST_LEFT;
      end
      ST_LEFT: begin
        state_nxt = ST_RIGHT;
      end
      ST_RIGHT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
      last_err_r  <= '0;
      ierr_r      <= '0;
    end else begin
      state_r <= state_nxt;
      mcnt_r  <= mcnt_nxt;
      if (state_r == ST_RIGHT && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // loop state moves on once per item
      if (state_r == ST_ERR) begin
        last_err_r <= err_c;
        ierr_r     <= integ_c;
      end
    end
  end

  // configuration writes, each truncated to its register width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_RST;
      pgain_r <= PGAIN_RST;
      igain_r <= IGAIN_RST;
      dgain_r <= DGAIN_RST;
      lim_r   <= LIM_RST;
      base_r  <= BASE_RST;
      min_r   <= MIN_RST;
      max_r   <= MAX_RST;
    end else if (cfg_we) begin
      unique case (lpd_reg_t'(cfg_idx))
        REG_BLACK_THR:  thr_r   <= cfg_data[THR_W-1:0];
        REG_PROP_GAIN:  pgain_r <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN: igain_r <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN: dgain_r <= cfg_data[GAIN_W-1:0];
        REG_INTEG_LIM:  lim_r   <= cfg_data[LIM_W-1:0];
        REG_BASE_DUTY:  base_r  <= cfg_data[DUTY_W-1:0];
        REG_MIN_DUTY:   min_r   <= cfg_data[DUTY_W-1:0];
        REG_MAX_DUTY:   max_r   <= cfg_data[DUTY_W-1:0];
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lost_r <= lost_c;
      neg_r  <= wsum_c[WSUM_W-1];
    end
    if (state_r == ST_ERR) begin
      err_r   <= err_c;
      integ_r <= integ_c;
      diff_r  <= diff_c;
    end
    if (state_r == ST_CORR) begin
      corr_r <= corr_c;
    end
    if (state_r == ST_LEFT) begin
      left_r <= duty_c;
    end
    if (state_r == ST_RIGHT && out_load) begin
      out_left_r  <= left_r;
      out_right_r <= duty_c;
      out_err_r   <= err_r;
      out_lost_r  <= lost_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.left_duty  = out_left_r;
  assign out_ch.right_duty = out_right_r;
  assign out_ch.line_error = out_err_r;
  assign out_ch.line_lost  = out_lost_r;

  // an accepted item either divides or goes straight to the error step
  `LPD_ASSERT_NEXT(a_accept_starts, in_acc, state_r == ST_DIV || state_r == ST_ERR)
  // the divider only runs while the sequencer waits on it
  `LPD_ASSERT_SAME(a_div_in_div, div_stat.busy, state_r == ST_DIV)
  // loop state already holds this item's error while products are formed
  `LPD_ASSERT_SAME(a_last_err_upd, state_r == ST_MUL, last_err_r == err_r)
  // saturation keeps the error off the most negative code
  `LPD_ASSERT_SAME(a_err_sat, state_r == ST_MUL, err_r != ERR_NEVER)
  // a new result comes only out of the last step
  `LPD_ASSERT_SAME(a_out_from_right, $rose(out_valid_r), $past(state_r) == ST_RIGHT)

endmodule

// ----- design/lpd_div.sv -----
// restoring divider, one quotient bit per cycle
module lpd_div import lpd_pkg::*; #(
  parameter int QUO_W = 10,
  parameter int NUM_W = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [SUM_W-1:0]   den,
  output logic [QUO_W-1:0]   quo,
  output lpd_div_stat_t      stat
);

  localparam int DW    = SUM_W + QUO_W - 1;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             ge;

  assign ge = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = DW'(num);
      dsh_nxt  = DW'(den) << (QUO_W - 1);
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(QUO_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign quo       = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- design/lpd_mac.sv -----
// shared multiplier with registered product and accumulator
module lpd_mac import lpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lpd_mac_ctl_t            ctl,
  input  logic [GAIN_W-1:0]       gain,
  input  logic signed [ERR_W:0]   opnd,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic signed [ACC_W-1:0]  acc_r;

  // gain is unsigned, so a zero sign bit goes in front
  assign prod_c = $signed({1'b0, gain}) * opnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      prod_r <= prod_c;
    end
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule
